[rtl/ujsc_pkg.sv]
// Shared types, character codes and breakpoint patterns for the sentence chunker.
`default_nettype none
package ujsc_pkg;

    localparam int CFG_W         = 12;
    localparam int BYTE_CNT_W    = 15;
    localparam int CHAR_CNT_W    = 13;
    localparam int Q_DEPTH       = 4;
    localparam int BP_COUNT      = 6;
    localparam int BP_MAX_BYTES  = 12;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd300;

    typedef logic [7:0] t_byte;
    typedef logic [23:0] t_char3;
    typedef logic [BP_MAX_BYTES*8-1:0] t_bp_seq;

    typedef struct packed {
        t_byte data_byte;
        logic  eot;
        logic  is_err;
    } t_q_word;

    localparam t_char3 CH_PERIOD = 24'hE38082;
    localparam t_char3 CH_EXCL   = 24'hEFBC81;
    localparam t_char3 CH_QUEST  = 24'hEFBC9F;
    localparam t_char3 CH_OPEN   = 24'hE3808C;
    localparam t_char3 CH_CLOSE  = 24'hE3808D;

    // First byte of each pattern sits in the top bits.
    localparam t_bp_seq BP_SEQ [BP_COUNT] = '{
        96'hE38081_000000_000000_000000,
        96'hE38082_000000_000000_000000,
        96'hE38197_E3818B_E38197_000000,
        96'hE3819D_E38197_E381A6_000000,
        96'hE381A0_E3818B_E38289_000000,
        96'hE3819D_E381AE_E3819F_E38281
    };
    localparam int BP_LEN [BP_COUNT] = '{3, 3, 9, 9, 9, 12};

    // Character length from a lead byte; zero for an invalid lead byte.
    function automatic logic [2:0] lead_len(input t_byte b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

[rtl/ujsc_if.sv]
// Stream interfaces for the input bytes and the marked output bytes.
`default_nettype none
interface ujsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface ujsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       sentence_end;
    logic       status;

    modport source (output valid, output out_byte, output chunk_end,
                    output sentence_end, output status, input ready);
    modport sink (input valid, input out_byte, input chunk_end,
                  input sentence_end, input status, output ready);
endinterface
`default_nettype wire

[rtl/ujsc_front.sv]
// Front end: accepts bytes, tracks character lengths and the error drop state.
`default_nettype none
module ujsc_front import ujsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ujsc_in_if.sink   i_in,
    input  wire logic i_q_ready,
    output t_q_word   o_q_word,
    output logic      o_q_push
);

    logic [1:0] r_char_left, n_char_left;
    logic       r_err, n_err;
    logic       accept;
    logic [2:0] len;

    assign i_in.ready = r_err | i_q_ready;
    assign accept     = i_in.valid & i_in.ready;
    assign len        = lead_len(i_in.data_byte);

    always_comb begin
        n_char_left        = r_char_left;
        n_err              = r_err;
        o_q_push           = 1'b0;
        o_q_word.data_byte = i_in.data_byte;
        o_q_word.eot       = i_in.end_of_text;
        o_q_word.is_err    = 1'b0;
        if (accept) begin
            if (r_err) begin
                if (i_in.end_of_text) begin
                    n_err = 1'b0;
                end
            end else if (r_char_left != 2'd0) begin
                o_q_push    = 1'b1;
                n_char_left = i_in.end_of_text ? 2'd0 : r_char_left - 2'd1;
            end else if (len == 3'd0) begin
                o_q_push        = 1'b1;
                o_q_word.is_err = 1'b1;
                n_err           = ~i_in.end_of_text;
            end else begin
                o_q_push    = 1'b1;
                n_char_left = i_in.end_of_text ? 2'd0 : 2'(len - 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_left <= 2'd0;
            r_err       <= 1'b0;
        end else begin
            r_char_left <= n_char_left;
            r_err       <= n_err;
        end
    end

endmodule
`default_nettype wire

[rtl/ujsc_queue.sv]
// Small register queue between the front end and the back end.
`default_nettype none
module ujsc_queue import ujsc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_word i_word,
    output logic         o_ready,
    input  wire logic    i_pop,
    output t_q_word      o_word,
    output logic         o_valid
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_q_word            r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && o_ready) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push && o_ready) - CNT_W'(i_pop && o_valid);
        end
    end

endmodule
`default_nettype wire

[rtl/ujsc_back.sv]
// Back end: lookahead window, boundary decisions and the output register.
`default_nettype none
module ujsc_back import ujsc_pkg::*; #(
    parameter int LOOKAHEAD_BYTES = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_max_len,
    input  wire logic             i_q_valid,
    input  wire t_q_word          i_q_word,
    output logic                  o_q_pop,
    ujsc_out_if.source            o_out
);

    localparam int FILL_W = $clog2(LOOKAHEAD_BYTES + 1);

    t_byte                  r_win [LOOKAHEAD_BYTES];
    t_byte                  n_win [LOOKAHEAD_BYTES];
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [1:0]             r_pend, n_pend;
    logic                   r_fin, n_fin;
    logic                   r_term, n_term;
    logic                   r_flush, n_flush;
    logic [BYTE_CNT_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [CHAR_CNT_W-1:0]  r_char_cnt, n_char_cnt;
    logic                   r_quote, n_quote;
    logic                   r_out_valid;
    t_byte                  r_out_byte;
    logic                   r_out_ce, r_out_se, r_out_st;

    logic                   out_free;
    logic                   win_full;
    logic                   can_decide;
    logic                   emit_win;
    logic                   err_emit;
    logic                   err_flush;
    logic                   take;
    logic                   flush_last;
    logic                   flush_done;
    logic [2:0]             len1;
    logic [2:0]             clen;
    t_char3                 head3;
    logic                   is_open, is_close;
    logic                   q_next;
    logic                   term;
    logic                   bp_hit;
    logic [BYTE_CNT_W-1:0]  byte_sum;
    logic [CHAR_CNT_W-1:0]  char_sum;
    logic                   fin;
    logic                   last_c;
    logic                   emit_ce, emit_se;
    logic [FILL_W-1:0]      wr_idx;

    assign out_free   = ~r_out_valid | o_out.ready;
    assign win_full   = (r_fill == FILL_W'(LOOKAHEAD_BYTES));
    assign can_decide = (r_pend == 2'd0) && (r_fill != '0) && (r_flush || win_full);
    assign emit_win   = out_free && ((r_pend != 2'd0) || can_decide);
    assign err_emit   = out_free && i_q_valid && i_q_word.is_err && (r_fill == '0) && !r_flush;
    assign err_flush  = i_q_valid && i_q_word.is_err && (r_fill != '0) && !r_flush;
    assign take       = i_q_valid && !i_q_word.is_err && !r_flush && (!win_full || emit_win);
    assign o_q_pop    = take || err_emit;
    assign flush_last = r_flush && (r_fill == FILL_W'(1));
    assign flush_done = flush_last && emit_win;

    always_comb begin
        len1     = (lead_len(r_win[0]) == 3'd0) ? 3'd1 : lead_len(r_win[0]);
        clen     = (FILL_W'(len1) < r_fill) ? len1 : r_fill[2:0];
        head3    = {r_win[0], r_win[1], r_win[2]};
        is_open  = (clen == 3'd3) && (head3 == CH_OPEN);
        is_close = (clen == 3'd3) && (head3 == CH_CLOSE);
        q_next   = is_open ? 1'b1 : (is_close ? 1'b0 : r_quote);
        term     = (clen == 3'd3) && !q_next &&
                   ((head3 == CH_PERIOD) || (head3 == CH_EXCL) || (head3 == CH_QUEST));
        bp_hit   = 1'b0;
        for (int k = 0; k < BP_COUNT; k++) begin
            logic hit;
            hit = (FILL_W'(BP_LEN[k]) <= r_fill);
            for (int i = 0; i < BP_MAX_BYTES; i++) begin
                if (i < BP_LEN[k]) begin
                    hit = hit && (r_win[i] == BP_SEQ[k][BP_MAX_BYTES*8-1-8*i -: 8]);
                end
            end
            bp_hit = bp_hit | hit;
        end
        byte_sum = r_byte_cnt + BYTE_CNT_W'(clen);
        char_sum = r_char_cnt + CHAR_CNT_W'(1);
        fin      = term || (bp_hit && (byte_sum > BYTE_CNT_W'(i_max_len))) ||
                   (char_sum > CHAR_CNT_W'(i_max_len));
    end

    always_comb begin
        n_pend     = r_pend;
        n_fin      = r_fin;
        n_term     = r_term;
        n_byte_cnt = r_byte_cnt;
        n_char_cnt = r_char_cnt;
        n_quote    = r_quote;
        last_c     = 1'b0;
        emit_ce    = 1'b0;
        emit_se    = 1'b0;
        if (r_pend != 2'd0) begin
            last_c  = (r_pend == 2'd1);
            emit_ce = (last_c && r_fin) || flush_last;
            emit_se = last_c && r_term;
        end else begin
            last_c  = (clen == 3'd1);
            emit_ce = (last_c && fin) || flush_last;
            emit_se = last_c && term;
        end
        if (emit_win) begin
            if (r_pend != 2'd0) begin
                n_pend = r_pend - 2'd1;
            end else begin
                n_pend     = 2'(clen - 3'd1);
                n_fin      = fin;
                n_term     = term;
                n_quote    = q_next;
                n_byte_cnt = fin ? '0 : byte_sum;
                n_char_cnt = fin ? '0 : char_sum;
            end
        end
        if (flush_done) begin
            n_byte_cnt = '0;
            n_char_cnt = '0;
            n_quote    = 1'b0;
        end
        n_flush = flush_done ? 1'b0 : (r_flush || err_flush || (take && i_q_word.eot));
    end

    always_comb begin
        wr_idx = r_fill - FILL_W'(emit_win);
        n_fill = r_fill - FILL_W'(emit_win) + FILL_W'(take);
        for (int i = 0; i < LOOKAHEAD_BYTES; i++) begin
            n_win[i] = r_win[i];
            if (emit_win && (i < LOOKAHEAD_BYTES - 1)) begin
                n_win[i] = r_win[(i < LOOKAHEAD_BYTES - 1) ? i + 1 : i];
            end
            if (take && (wr_idx == FILL_W'(i))) begin
                n_win[i] = i_q_word.data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (out_free) begin
            if (err_emit) begin
                r_out_byte <= i_q_word.data_byte;
                r_out_ce   <= 1'b0;
                r_out_se   <= 1'b0;
                r_out_st   <= 1'b1;
            end else begin
                r_out_byte <= r_win[0];
                r_out_ce   <= emit_ce;
                r_out_se   <= emit_se;
                r_out_st   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 2'd0;
            r_fin       <= 1'b0;
            r_term      <= 1'b0;
            r_flush     <= 1'b0;
            r_byte_cnt  <= '0;
            r_char_cnt  <= '0;
            r_quote     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_pend     <= n_pend;
            r_fin      <= n_fin;
            r_term     <= n_term;
            r_flush    <= n_flush;
            r_byte_cnt <= n_byte_cnt;
            r_char_cnt <= n_char_cnt;
            r_quote    <= n_quote;
            if (out_free) begin
                r_out_valid <= emit_win || err_emit;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.chunk_end    = r_out_ce;
    assign o_out.sentence_end = r_out_se;
    assign o_out.status       = r_out_st;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LOOKAHEAD_BYTES))
        else $error("Lookahead window overfilled.");

    a_pend_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> (FILL_W'(r_pend) <= r_fill))
        else $error("Character continuation bytes missing from the window.");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_flush) |-> (r_fill == '0 && r_byte_cnt == '0 && r_char_cnt == '0 && !r_quote))
        else $error("Flush ended with state left behind.");

    a_no_intake_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !take)
        else $error("Byte taken into the window during a flush.");

endmodule
`default_nettype wire

[rtl/utf8_japanese_sentence_chunker.sv]
// Top level of the UTF-8 Japanese sentence and chunk boundary marker.
//
//  Port          Dir  Handshake      Contents
//  i_in          in   valid/ready    data_byte, end_of_text
//  o_out         out  valid/ready    out_byte, chunk_end, sentence_end, status
//  i_cfg_we      in   write enable   i_cfg_wdata: max_chunk_length
//
// Outside a drain, one byte per cycle is sustained in and out; a character starts
// to leave the lookahead window once the window holds LOOKAHEAD_BYTES bytes from
// its lead byte on. At end of text or an invalid lead byte the window drains one
// byte per cycle while a four-word queue keeps taking input.
// Reset is synchronous and clears all control state; max_chunk_length returns to 300.
// A stalled output holds its register and backs up through the window and queue.
`default_nettype none
module utf8_japanese_sentence_chunker import ujsc_pkg::*; #(
    parameter int LOOKAHEAD_BYTES = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    ujsc_in_if.sink               i_in,
    ujsc_out_if.source            o_out
);

    logic [CFG_W-1:0] r_max_len;
    t_q_word          push_word;
    t_q_word          head_word;
    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    ujsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_word  (push_word),
        .o_q_push  (push)
    );

    ujsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_valid (q_valid)
    );

    ujsc_back #(
        .LOOKAHEAD_BYTES (LOOKAHEAD_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_len (r_max_len),
        .i_q_valid (q_valid),
        .i_q_word  (head_word),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the UTF-8 sentence chunker, driving text through both stream ports.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ujsc_pkg::*;

    localparam int WINDOW_BYTES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_BYTES  = 270;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CFG_W-1:0] RESET_LIMIT = 12'd300;

    localparam logic [23:0] IDEO_COMMA  = 24'hE38081;
    localparam logic [23:0] IDEO_PERIOD = 24'hE38082;
    localparam logic [23:0] FW_EXCL     = 24'hEFBC81;
    localparam logic [23:0] FW_QUEST    = 24'hEFBC9F;
    localparam logic [23:0] QUOTE_OPEN  = 24'hE3808C;
    localparam logic [23:0] QUOTE_CLOSE = 24'hE3808D;

    localparam logic [95:0] BREAK_SEQ [6] = '{
        96'hE38081_000000_000000_000000,
        96'hE38082_000000_000000_000000,
        96'hE38197_E3818B_E38197_000000,
        96'hE3819D_E38197_E381A6_000000,
        96'hE381A0_E3818B_E38289_000000,
        96'hE3819D_E381AE_E3819F_E38281
    };
    localparam int BREAK_LEN [6] = '{3, 3, 9, 9, 9, 12};

    typedef struct packed {
        t_byte out_byte;
        logic  chunk_end;
        logic  sentence_end;
        logic  status;
    } t_mark;

    class chunk_scoreboard;
        t_byte            window [WINDOW_BYTES];
        int unsigned      fill;
        logic [14:0]      chunk_bytes;
        logic [12:0]      chunk_chars;
        int unsigned      cont_left;
        bit               in_quote;
        bit               dropping;
        logic [CFG_W-1:0] limit;
        t_mark            marks_due [$];
        int unsigned      emitted;
        int unsigned      taken;
        int               errors;

        function new();
            limit       = RESET_LIMIT;
            fill        = 0;
            chunk_bytes = '0;
            chunk_chars = '0;
            cont_left   = 0;
            in_quote    = 1'b0;
            dropping    = 1'b0;
            taken       = 0;
            errors      = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return marks_due.size();
        endfunction

        function void queue_mark(t_mark m);
            marks_due = {marks_due, m};
        endfunction

        function int unsigned char_bytes(t_byte b);
            casez (b)
                8'b0???????: return 1;
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 0;
            endcase
        endfunction

        function bit front_is(logic [23:0] code, int unsigned clen);
            return clen == 3 && {window[0], window[1], window[2]} == code;
        endfunction

        function bit at_breakpoint();
            bit hit;
            for (int k = 0; k < 6; k++) begin
                if (BREAK_LEN[k] <= fill) begin
                    hit = 1'b1;
                    for (int i = 0; i < BREAK_LEN[k]; i++) begin
                        if (window[i] != BREAK_SEQ[k][95 - 8*i -: 8]) hit = 1'b0;
                    end
                    if (hit) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void emit_front();
            int unsigned clen;
            bit          term;
            bit          fin;
            t_mark       m;
            clen = char_bytes(window[0]);
            if (clen == 0) clen = 1;
            if (clen > fill) clen = fill;
            if (front_is(QUOTE_OPEN, clen)) begin
                in_quote = 1'b1;
            end else if (front_is(QUOTE_CLOSE, clen)) begin
                in_quote = 1'b0;
            end
            term = (front_is(IDEO_PERIOD, clen) || front_is(FW_EXCL, clen) ||
                    front_is(FW_QUEST, clen)) && !in_quote;
            chunk_bytes = chunk_bytes + 15'(clen);
            chunk_chars = chunk_chars + 13'd1;
            fin = term || (at_breakpoint() && chunk_bytes > 15'(limit)) ||
                  chunk_chars > 13'(limit);
            for (int i = 0; i < clen; i++) begin
                m.out_byte     = window[i];
                m.chunk_end    = (i == clen - 1) && fin;
                m.sentence_end = (i == clen - 1) && term;
                m.status       = 1'b0;
                queue_mark(m);
                emitted++;
            end
            if (fin) begin
                chunk_bytes = '0;
                chunk_chars = '0;
            end
            for (int i = 0; i + clen < fill; i++) window[i] = window[i + clen];
            fill -= clen;
        endfunction

        function void flush_window();
            t_mark m;
            while (fill > 0) emit_front();
            if (chunk_bytes != 0 && emitted > 0) begin
                m = marks_due.pop_back();
                m.chunk_end = 1'b1;
                queue_mark(m);
            end
            chunk_bytes = '0;
            chunk_chars = '0;
            cont_left   = 0;
            in_quote    = 1'b0;
        endfunction

        function void note_byte(t_byte b, logic eot);
            int unsigned len;
            t_mark       m;
            if (dropping) begin
                if (eot) dropping = 1'b0;
                return;
            end
            taken++;
            emitted = 0;
            if (cont_left > 0) begin
                cont_left--;
            end else begin
                len = char_bytes(b);
                if (len == 0) begin
                    flush_window();
                    m.out_byte     = b;
                    m.chunk_end    = 1'b0;
                    m.sentence_end = 1'b0;
                    m.status       = 1'b1;
                    queue_mark(m);
                    fill     = 0;
                    dropping = !eot;
                    return;
                end
                cont_left = len - 1;
            end
            if (fill < WINDOW_BYTES) begin
                window[fill] = b;
                fill++;
            end
            if (eot) begin
                flush_window();
                fill = 0;
            end else if (fill >= WINDOW_BYTES) begin
                emit_front();
            end
        endfunction

        function void check_mark(t_mark got);
            t_mark want;
            if (marks_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch: unexpected word byte %h chunk_end %b",
                             got.out_byte, got.chunk_end,
                             " sentence_end %b status %b", got.sentence_end, got.status);
                end
                return;
            end
            want = marks_due.pop_front();
            if (got.out_byte !== want.out_byte || got.chunk_end !== want.chunk_end ||
                got.sentence_end !== want.sentence_end || got.status !== want.status) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch: expected byte %h ce %b se %b st %b,",
                             want.out_byte, want.chunk_end, want.sentence_end, want.status,
                             " got byte %h ce %b se %b st %b",
                             got.out_byte, got.chunk_end, got.sentence_end, got.status);
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    bit               idle_on = 1'b0;
    int               stall_left = 0;
    int               cycle_count = 0;
    t_byte            text_bytes [$];
    chunk_scoreboard  sb;

    ujsc_in_if  in_if ();
    ujsc_out_if out_if ();

    utf8_japanese_sentence_chunker uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // An accepted input word is noted before the output word of the same edge is checked.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte, in_if.end_of_text);
            if (out_if.valid && out_if.ready) begin
                sb.check_mark(t_mark'({out_if.out_byte, out_if.chunk_end,
                                       out_if.sentence_end, out_if.status}));
            end
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic send_byte(input t_byte b, input logic eot);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b;
        in_if.end_of_text <= eot;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    task automatic end_phase();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    function automatic void add_byte(t_byte b);
        text_bytes = {text_bytes, b};
    endfunction

    function automatic void push_code(logic [23:0] code);
        add_byte(code[23:16]);
        add_byte(code[15:8]);
        add_byte(code[7:0]);
    endfunction

    function automatic void push_any(int count);
        repeat (count) add_byte(t_byte'($urandom_range(0, 255)));
    endfunction

    function automatic void push_char();
        int sel;
        int k;
        int n;
        sel = $urandom_range(0, 11);
        case (sel)
            0, 1: begin
                add_byte(t_byte'($urandom_range(0, 127)));
            end
            2: begin
                add_byte({3'b110, 5'($urandom)});
                push_any(1);
            end
            3, 4: begin
                add_byte(8'hE3);
                add_byte(t_byte'($urandom_range(8'h81, 8'h82)));
                add_byte(t_byte'($urandom_range(8'h80, 8'hBF)));
            end
            5, 6: begin
                k = $urandom_range(0, 5);
                n = (sel == 5) ? BREAK_LEN[k] : 3 * $urandom_range(1, BREAK_LEN[k] / 3);
                for (int i = 0; i < n; i++) add_byte(BREAK_SEQ[k][95 - 8*i -: 8]);
            end
            7: begin
                case ($urandom_range(0, 2))
                    0:       push_code(IDEO_PERIOD);
                    1:       push_code(FW_EXCL);
                    default: push_code(FW_QUEST);
                endcase
            end
            8: begin
                push_code($urandom_range(0, 1) ? QUOTE_OPEN : QUOTE_CLOSE);
            end
            9: begin
                add_byte({5'b11110, 3'($urandom)});
                push_any(3);
            end
            10: begin
                add_byte({4'b1110, 4'($urandom)});
                push_any(2);
            end
            default: begin
                push_code(IDEO_COMMA);
            end
        endcase
    endfunction

    // Most texts are well formed; a few are noise, end in a broken character or hit a bad lead byte.
    function automatic void build_text();
        int shape;
        text_bytes.delete();
        shape = $urandom_range(0, 15);
        if (shape == 0) begin
            push_any($urandom_range(1, 16));
            return;
        end
        repeat ($urandom_range(1, 14)) push_char();
        if (shape <= 2) begin
            add_byte(t_byte'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                                 : $urandom_range(8'hF8, 8'hFF)));
            push_any($urandom_range(0, 4));
        end else if (shape <= 4) begin
            case ($urandom_range(0, 2))
                0: add_byte(8'hE3);
                1: begin
                    add_byte(8'hE3);
                    add_byte(8'h81);
                end
                default: begin
                    add_byte({5'b11110, 3'($urandom)});
                    push_any($urandom_range(0, 2));
                end
            endcase
        end
    endfunction

    initial begin : stimulus
        int               phase;
        int unsigned      base;
        logic [CFG_W-1:0] next_limit;
        sb = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = '0;
        in_if.end_of_text = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        text_bytes = '{8'hE3, 8'h80, 8'h8C, 8'hE3, 8'h80, 8'h82,
                       8'hE3, 8'h80, 8'h8D, 8'hE3, 8'h80, 8'h82};
        send_text();
        text_bytes = '{8'h00, 8'hFF, 8'h41, 8'h42};
        send_text();
        text_bytes = '{8'h80};
        send_text();
        text_bytes = '{8'hE3, 8'h81};
        send_text();
        text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F};
        send_text();
        end_phase();

        phase = 0;
        base  = sb.taken;
        while (sb.taken - base < RANDOM_BYTES) begin
            case (phase)
                0:       next_limit = 12'd1;
                1:       next_limit = 12'd0;
                2:       next_limit = 12'd4095;
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        next_limit = 12'($urandom_range(0, 4095));
                    end else begin
                        next_limit = 12'($urandom_range(1, 12));
                    end
                end
            endcase
            idle_on = (sb.taken - base < RANDOM_BYTES * 4 / 5) && ($urandom_range(0, 3) != 0);
            write_limit(next_limit);
            repeat ($urandom_range(1, 2)) begin
                build_text();
                send_text();
            end
            end_phase();
            phase++;
        end

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
